// ----- rtl/lfco_pkg.sv -----
package lfco_pkg;

   localparam int MAX_ROWS = 1024;
   localparam int MAX_COLS = 64;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int CNT_W    = 11;
   localparam int CCNT_W   = 7;
   localparam int DATA_W   = 32;
   localparam int RES_W    = 40;
   localparam int ACC_W    = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [1:0] MODE_LOAD_TBL  = 2'd0;
   localparam logic [1:0] MODE_LOAD_COEF = 2'd1;
   localparam logic [1:0] MODE_EVAL      = 2'd2;

   localparam logic [2:0] KIND_PASS_HIGH = 3'd0;
   localparam logic [2:0] KIND_PASS_LOW  = 3'd1;
   localparam logic [2:0] KIND_STOP_HIGH = 3'd2;
   localparam logic [2:0] KIND_STOP_NEG  = 3'd3;
   localparam logic [2:0] KIND_TRANS_NEG = 3'd4;
   localparam logic [2:0] KIND_COEF_NEG  = 3'd5;
   localparam logic [2:0] KIND_OBJECTIVE = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_PASS_ROWS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_START = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_LOW   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_HIGH  = 3'd5;

   localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
   localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE, S_NEXT, S_ISSUE, S_DRAIN, S_ROUND, S_CHECK, S_COEF, S_COEF_CHK
   } state_type;

   typedef enum logic [1:0] {
      PH_PASS, PH_STOP, PH_TRANS
   } phase_type;

   typedef struct packed {
      logic              load_tbl;
      logic              load_coef;
      logic              start;
      logic              rd;
      logic              mac;
      logic              acc_clr;
      logic              round;
      logic              check;
      logic              coef_chk;
      phase_type         phase;
      logic [CNT_W-1:0]  row;
      logic [CCNT_W-1:0] col;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]  rows;
      logic [CCNT_W-1:0] cols;
      logic [CNT_W-1:0]  np;
      logic [CNT_W-1:0]  ns;
      logic              busy;
      logic              viol;
      logic              out_busy;
   } stat_type;

   // clamp a wide signed value to the 40-bit result range
   function automatic logic signed [RES_W-1:0] sat_res(input logic signed [ACC_W:0] v);
      logic signed [ACC_W:0] hi;
      logic signed [ACC_W:0] lo;
      hi = (ACC_W+1)'(RES_MAX);
      lo = (ACC_W+1)'(RES_MIN);
      if (v > hi) begin
         return RES_MAX;
      end else if (v < lo) begin
         return RES_MIN;
      end
      return v[RES_W-1:0];
   endfunction

endpackage

// ----- rtl/lfco_ctrl.sv -----
module lfco_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_mode,
   output logic                req_ready,
   input  lfco_pkg::stat_type  stat,
   output lfco_pkg::cmd_type   cmd
);
   import lfco_pkg::*;

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  row_ff, row_in;
   logic [CCNT_W-1:0] col_ff, col_in;
   logic              accept;
   logic              rows_left;

   assign accept = req_valid && req_ready;

   always_comb begin
      case (phase_ff)
         PH_PASS:  rows_left = row_ff < stat.np;
         PH_STOP:  rows_left = row_ff < stat.rows;
         PH_TRANS: rows_left = row_ff < stat.ns;
         default:  rows_left = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_mode == MODE_EVAL) begin
               state_in = S_NEXT;
               phase_in = PH_PASS;
               row_in   = '0;
            end
         end
         S_NEXT: begin
            col_in = '0;
            if (rows_left) begin
               state_in = (stat.cols == '0) ? S_DRAIN : S_ISSUE;
            end else begin
               case (phase_ff)
                  PH_PASS: begin
                     phase_in = PH_STOP;
                     row_in   = stat.ns;
                  end
                  PH_STOP: begin
                     phase_in = PH_TRANS;
                     row_in   = stat.np;
                  end
                  default: begin
                     state_in = S_COEF;
                  end
               endcase
            end
         end
         S_ISSUE: begin
            col_in = col_ff + 1'b1;
            if (col_ff == stat.cols - 1'b1) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!stat.busy) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.viol) begin
               state_in = S_COEF_CHK;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = S_NEXT;
            end
         end
         S_COEF: begin
            state_in = S_COEF_CHK;
         end
         S_COEF_CHK: begin
            // result register holds the verdict; wait for the output slot
            if (!stat.out_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      cmd           = '0;
      cmd.phase     = phase_ff;
      cmd.row       = row_ff;
      cmd.col       = col_ff;
      cmd.load_tbl  = accept && req_mode == MODE_LOAD_TBL;
      cmd.load_coef = accept && req_mode == MODE_LOAD_COEF;
      cmd.start     = accept && req_mode == MODE_EVAL;
      case (state_ff)
         S_NEXT:  cmd.acc_clr = 1'b1;
         S_ISSUE: begin
            cmd.rd  = 1'b1;
            cmd.mac = 1'b1;
         end
         S_ROUND: cmd.round = 1'b1;
         S_CHECK: cmd.check = 1'b1;
         S_COEF: begin
            cmd.rd  = 1'b1;
            cmd.col = '0;
         end
         S_COEF_CHK: cmd.coef_chk = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_PASS;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

endmodule

// ----- rtl/lfco_dp.sv -----
module lfco_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lfco_pkg::cmd_type                    cmd,
   output lfco_pkg::stat_type                   stat,
   input  logic [lfco_pkg::ROW_W-1:0]           req_row_index,
   input  logic [lfco_pkg::COL_W-1:0]           req_col_index,
   input  logic signed [lfco_pkg::DATA_W-1:0]   req_element_value,
   input  logic [lfco_pkg::DATA_W-1:0]          req_stop_limit,
   input  logic                                 csr_write_en,
   input  logic [lfco_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lfco_pkg::DATA_W-1:0]          csr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_cut_kind,
   output logic [lfco_pkg::ROW_W-1:0]           rsp_cut_row,
   output logic signed [lfco_pkg::RES_W-1:0]    rsp_cut_first,
   output logic signed [lfco_pkg::RES_W-1:0]    rsp_cut_second,
   output logic                                 rsp_single_cut,
   output logic                                 rsp_more_alternatives,
   output logic signed [lfco_pkg::RES_W-1:0]    rsp_new_objective
);
   import lfco_pkg::*;

   localparam int W = ACC_W + 1;
   localparam logic signed [W-1:0] HALF_LSB = W'(64'sd8388608);

   logic [CNT_W-1:0]  pass_rows_ff, stop_start_ff, row_count_ff;
   logic [CCNT_W-1:0] col_count_ff;
   logic [DATA_W-1:0] pass_low_ff, pass_high_ff, limit_ff;

   logic signed [DATA_W-1:0] tbl_mem [0:MAX_ROWS*MAX_COLS-1];
   logic signed [DATA_W-1:0] coef_mem [0:MAX_COLS-1];
   logic signed [DATA_W-1:0] tbl_q_ff, coef_q_ff;
   logic signed [ACC_W-1:0]  prod_ff, acc_ff;
   logic                     rd_vld_ff, prod_vld_ff;
   logic signed [RES_W-1:0]  v_ff, fmax_ff;
   logic [ROW_W-1:0]         imax_ff;
   logic                     have_max_ff;

   logic [2:0]              res_kind_ff;
   logic [ROW_W-1:0]        res_row_ff;
   logic signed [RES_W-1:0] res_first_ff, res_second_ff;
   logic                    res_single_ff, res_more_ff;
   logic                    out_vld_ff;

   logic [CNT_W-1:0]        rows;
   logic signed [W-1:0]     acc_sum, rnd_sum, rnd_sh;
   logic signed [W-1:0]     v_w, hi_w, lo_w, lim_w, coef_w;
   logic                    viol;
   logic [2:0]              c_kind;
   logic signed [W-1:0]     c_first, c_second;
   logic                    c_single;
   logic                    out_load;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_rows_ff  <= '0;
         stop_start_ff <= '0;
         row_count_ff  <= CNT_W'(MAX_ROWS);
         col_count_ff  <= CCNT_W'(MAX_COLS);
         pass_low_ff   <= '0;
         pass_high_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PASS_ROWS:  pass_rows_ff  <= csr_data[CNT_W-1:0];
            CSR_STOP_START: stop_start_ff <= csr_data[CNT_W-1:0];
            CSR_ROW_COUNT:  row_count_ff  <= csr_data[CNT_W-1:0];
            CSR_COL_COUNT:  col_count_ff  <= csr_data[CCNT_W-1:0];
            CSR_PASS_LOW:   pass_low_ff   <= csr_data;
            CSR_PASS_HIGH:  pass_high_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rows = (row_count_ff > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_count_ff;

   always_comb begin
      stat.rows     = rows;
      stat.cols     = (col_count_ff > CCNT_W'(MAX_COLS)) ? CCNT_W'(MAX_COLS) : col_count_ff;
      stat.np       = (pass_rows_ff < rows) ? pass_rows_ff : rows;
      stat.ns       = (stop_start_ff < rows) ? stop_start_ff : rows;
      stat.busy     = rd_vld_ff || prod_vld_ff;
      stat.viol     = viol;
      stat.out_busy = out_vld_ff && !rsp_ready;
   end

   // memories, read data registered
   always_ff @(posedge clock) begin
      if (cmd.load_tbl) begin
         tbl_mem[{req_row_index, req_col_index}] <= req_element_value;
      end
      tbl_q_ff <= tbl_mem[{cmd.row[ROW_W-1:0], cmd.col[COL_W-1:0]}];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_coef) begin
         coef_mem[req_col_index] <= req_element_value;
      end
      coef_q_ff <= coef_mem[cmd.col[COL_W-1:0]];
   end

   // multiply-accumulate with saturation
   assign acc_sum = W'(acc_ff) + W'(prod_ff);

   always_ff @(posedge clock) begin
      prod_ff <= tbl_q_ff * coef_q_ff;
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         if (acc_sum[W-1] != acc_sum[W-2]) begin
            acc_ff <= acc_sum[W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
         end else begin
            acc_ff <= acc_sum[ACC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.rd && cmd.mac;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   // round half up to Q16.24
   assign rnd_sum = W'(acc_ff) + HALF_LSB;
   assign rnd_sh  = rnd_sum >>> 24;

   always_ff @(posedge clock) begin
      if (cmd.round) begin
         v_ff <= sat_res(rnd_sh);
      end
   end

   assign v_w    = W'(v_ff);
   assign hi_w   = W'({1'b0, pass_high_ff});
   assign lo_w   = W'({1'b0, pass_low_ff});
   assign lim_w  = W'({1'b0, limit_ff});
   assign coef_w = W'(coef_q_ff);

   always_comb begin
      viol     = 1'b0;
      c_kind   = KIND_PASS_HIGH;
      c_first  = '0;
      c_second = '0;
      c_single = 1'b0;
      case (cmd.phase)
         PH_PASS: begin
            if (v_w > hi_w) begin
               viol     = 1'b1;
               c_kind   = KIND_PASS_HIGH;
               c_first  = v_w - hi_w;
               c_second = v_w - lo_w;
            end else if (v_w < lo_w) begin
               viol     = 1'b1;
               c_kind   = KIND_PASS_LOW;
               c_first  = lo_w - v_w;
               c_second = hi_w - v_w;
            end
         end
         PH_STOP: begin
            if (v_w > lim_w) begin
               viol     = 1'b1;
               c_kind   = KIND_STOP_HIGH;
               c_first  = v_w - lim_w;
               c_second = v_w;
            end else if (v_w < 0) begin
               viol     = 1'b1;
               c_kind   = KIND_STOP_NEG;
               c_first  = -v_w;
               c_second = lim_w - v_w;
            end
         end
         default: begin
            if (v_w < 0) begin
               viol     = 1'b1;
               c_kind   = KIND_TRANS_NEG;
               c_first  = -v_w;
               c_single = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         limit_ff    <= req_stop_limit;
         have_max_ff <= 1'b0;
         fmax_ff     <= RES_MIN;
         imax_ff     <= '0;
      end else if (cmd.check && !viol && cmd.phase == PH_STOP) begin
         if (!have_max_ff || v_ff > fmax_ff) begin
            have_max_ff <= 1'b1;
            fmax_ff     <= v_ff;
            imax_ff     <= cmd.row[ROW_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check && viol) begin
         res_kind_ff   <= c_kind;
         res_row_ff    <= cmd.row[ROW_W-1:0];
         res_first_ff  <= sat_res(c_first);
         res_second_ff <= sat_res(c_second);
         res_single_ff <= c_single;
         res_more_ff   <= 1'b1;
      end
      if (cmd.start) begin
         res_more_ff <= 1'b0;
      end
   end

   // stored row cut, coefficient or objective verdict is formed directly at the output
   assign out_load = cmd.coef_chk && !(out_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_load) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (res_more_ff) begin
            rsp_cut_kind          <= res_kind_ff;
            rsp_cut_row           <= res_row_ff;
            rsp_cut_first         <= res_first_ff;
            rsp_cut_second        <= res_second_ff;
            rsp_single_cut        <= res_single_ff;
            rsp_more_alternatives <= 1'b1;
            rsp_new_objective     <= '0;
         end else if (coef_q_ff < 0) begin
            rsp_cut_kind          <= KIND_COEF_NEG;
            rsp_cut_row           <= '0;
            rsp_cut_first         <= sat_res(-coef_w);
            rsp_cut_second        <= '0;
            rsp_single_cut        <= 1'b1;
            rsp_more_alternatives <= 1'b0;
            rsp_new_objective     <= '0;
         end else begin
            rsp_cut_kind          <= KIND_OBJECTIVE;
            rsp_cut_row           <= imax_ff;
            rsp_cut_first         <= '0;
            rsp_cut_second        <= fmax_ff;
            rsp_single_cut        <= 1'b0;
            rsp_more_alternatives <= 1'b0;
            rsp_new_objective     <= fmax_ff;
         end
      end
   end

   assign rsp_valid = out_vld_ff;

endmodule

// ----- rtl/lowpass_fir_cut_oracle.sv -----
// Low-pass FIR cut oracle. Load words (mode 0 matrix entry, mode 1 coefficient)
// give no result; mode 3 is dropped. An evaluate word runs one
// multiply-accumulate per cycle through a single shared multiplier fed from
// the matrix and coefficient memories; the scan stops at the first violated
// row, and the coefficient check (skipped after a violated row) then loads
// the output register, waiting while an earlier result word is still held.
// One result word per evaluate; loads are not taken while an evaluate is
// running or waits to load its result word. The memories are not cleared
// after reset: read only entries that were written.
module lowpass_fir_cut_oracle (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic [lfco_pkg::ROW_W-1:0]           req_row_index,
   input  logic [lfco_pkg::COL_W-1:0]           req_col_index,
   input  logic signed [lfco_pkg::DATA_W-1:0]   req_element_value,
   input  logic [lfco_pkg::DATA_W-1:0]          req_stop_limit,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_cut_kind,
   output logic [lfco_pkg::ROW_W-1:0]           rsp_cut_row,
   output logic signed [lfco_pkg::RES_W-1:0]    rsp_cut_first,
   output logic signed [lfco_pkg::RES_W-1:0]    rsp_cut_second,
   output logic                                 rsp_single_cut,
   output logic                                 rsp_more_alternatives,
   output logic signed [lfco_pkg::RES_W-1:0]    rsp_new_objective,
   input  logic                                 csr_write_en,
   input  logic [lfco_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lfco_pkg::DATA_W-1:0]          csr_data
);
   import lfco_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lfco_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lfco_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_row_index         (req_row_index),
      .req_col_index         (req_col_index),
      .req_element_value     (req_element_value),
      .req_stop_limit        (req_stop_limit),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_cut_kind          (rsp_cut_kind),
      .rsp_cut_row           (rsp_cut_row),
      .rsp_cut_first         (rsp_cut_first),
      .rsp_cut_second        (rsp_cut_second),
      .rsp_single_cut        (rsp_single_cut),
      .rsp_more_alternatives (rsp_more_alternatives),
      .rsp_new_objective     (rsp_new_objective)
   );

`ifndef SYNTHESIS
   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.mac |-> !req_ready)
      else $error("input taken during row scan");

   a_single_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_single_cut ==
         (rsp_cut_kind == KIND_TRANS_NEG || rsp_cut_kind == KIND_COEF_NEG)))
      else $error("single cut flag does not match kind");

   a_objective_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cut_kind != KIND_OBJECTIVE |-> rsp_new_objective == '0)
      else $error("objective set on constraint cut");

   a_drain_before_round: assert property (@(posedge clock) disable iff (reset)
      cmd.round |-> !stat.busy)
      else $error("rounding before accumulator drained");
`endif

endmodule
